FILE: src/plin_pkg.sv
// ----------------------------------------------------------------------------
// plin_pkg
// Shared widths, item codes and word types of the piecewise linear
// interpolator.
// ----------------------------------------------------------------------------
package plin_pkg;

	localparam int MAX_POINTS = 32;
	localparam int IDX_W      = $clog2(MAX_POINTS);

	localparam int POS_W  = 24;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 6;
	localparam int SLOT_W = 5;
	localparam int SEG_W  = 5;
	localparam int PROD_W = POS_W + VAL_W;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] entry_index;
		logic [POS_W-1:0]  entry_position;
		logic [VAL_W-1:0]  entry_value;
		logic [POS_W-1:0]  query_position;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] result_value;
		logic             below_first;
		logic             above_last;
		logic [SEG_W-1:0] segment;
	} rsp_t;

	// one segment to blend: lower and upper breakpoint and the query
	typedef struct packed {
		logic [POS_W-1:0] x1;
		logic [VAL_W-1:0] y1;
		logic [POS_W-1:0] x2;
		logic [VAL_W-1:0] y2;
		logic [POS_W-1:0] q;
	} blend_req_t;

endpackage

FILE: src/plin_blend.sv
// ----------------------------------------------------------------------------
// plin_blend
// Segment blend: one multiply of the offset by the value span, then a
// bit-serial restoring divide by the position span, then add or subtract
// from the lower value with saturation.
// ----------------------------------------------------------------------------
module plin_blend (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  plin_pkg::blend_req_t      req,
	output logic                      done,
	output logic [plin_pkg::VAL_W-1:0] result
);
	import plin_pkg::*;

	localparam int DCNT_W = $clog2(VAL_W);

	typedef enum logic [1:0] {BL_IDLE, BL_MUL, BL_DIV, BL_FIN} bl_state_t;

	bl_state_t         bl_state_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [VAL_W-1:0]  result_q;

	logic [POS_W-1:0]  dq_q;
	logic [POS_W-1:0]  dx_q;
	logic [VAL_W-1:0]  dy_q;
	logic [VAL_W-1:0]  y1_q;
	logic              falling_q;
	logic [POS_W-1:0]  rem_q;
	logic [VAL_W-1:0]  sh_q;

	logic [PROD_W-1:0] prod;
	logic [POS_W+1:0]  trial;
	logic              qbit;
	logic [VAL_W:0]    sum;
	logic [VAL_W-1:0]  final_val;

	assign prod  = dq_q * dy_q;
	assign trial = {1'b0, rem_q, sh_q[VAL_W-1]} - {2'b00, dx_q};
	assign qbit  = !trial[POS_W+1];
	assign sum   = {1'b0, y1_q} + {1'b0, sh_q};

	always_comb begin
		if (falling_q) begin
			final_val = (sh_q > y1_q) ? '0 : y1_q - sh_q;
		end else begin
			final_val = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bl_state_q <= BL_IDLE;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (bl_state_q)
				BL_IDLE: begin
					if (start) bl_state_q <= BL_MUL;
				end
				BL_MUL: begin
					cnt_q      <= '0;
					bl_state_q <= BL_DIV;
				end
				BL_DIV: begin
					if (cnt_q == DCNT_W'(VAL_W - 1)) begin
						cnt_q      <= '0;
						bl_state_q <= BL_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				BL_FIN: begin
					result_q   <= final_val;
					done_q     <= 1'b1;
					bl_state_q <= BL_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (bl_state_q == BL_IDLE && start) begin
			dq_q      <= req.q - req.x1;
			dx_q      <= req.x2 - req.x1;
			falling_q <= req.y2 < req.y1;
			dy_q      <= (req.y2 < req.y1) ? req.y1 - req.y2 : req.y2 - req.y1;
			y1_q      <= req.y1;
		end
		// product loads straight into the remainder and shift registers
		if (bl_state_q == BL_MUL) begin
			{rem_q, sh_q} <= prod;
		end
		if (bl_state_q == BL_DIV) begin
			if (qbit) rem_q <= trial[POS_W-1:0];
			else      rem_q <= {rem_q[POS_W-2:0], sh_q[VAL_W-1]};
			sh_q <= {sh_q[VAL_W-2:0], qbit};
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> bl_state_q == BL_IDLE)
		else $error("blend start while busy");

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(bl_state_q) == BL_FIN)
		else $error("blend done without finishing step");

	a_cnt_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> bl_state_q == BL_DIV)
		else $error("divide counter running outside divide");
`endif

endmodule

FILE: src/piecewise_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit
// Breakpoint table in one synchronous memory, scanned one slot a cycle;
// a write word is taken whenever the unit is idle. A query scans from
// slot 0 to the first slot at or above its position, or the last in use,
// and answers clamped or interpolated (32-step serial divide). One query
// in flight at a time. Reset clears control and sets point_count to 1;
// table contents are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  plin_pkg::req_t             req_word,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output plin_pkg::rsp_t             rsp_word,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [plin_pkg::CNT_W-1:0] cfg_data
);
	import plin_pkg::*;

	localparam int ENTRY_W = POS_W + VAL_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_BLEND, ST_EMIT} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  addr_q;
	logic              chk_v_s1;
	logic [IDX_W-1:0]  chk_idx_s1;
	logic              blend_start_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic [CNT_W-1:0]  point_count_q;

	logic [ENTRY_W-1:0] table_mem [MAX_POINTS];
	logic [ENTRY_W-1:0] rd_entry_s1;
	logic [POS_W-1:0]   rd_pos;
	logic [VAL_W-1:0]   rd_val;

	logic [POS_W-1:0]  q_pos_q;
	logic [POS_W-1:0]  prev_pos_q;
	logic [VAL_W-1:0]  prev_val_q;
	blend_req_t        blend_req_q;
	rsp_t              pend_q;

	logic              accept;
	logic              wr_en;
	logic              query_start;
	logic [IDX_W-1:0]  last_idx;
	logic              hit;
	logic              at_last;
	logic              blend_done;
	logic [VAL_W-1:0]  blend_result;

	assign req_stall   = (state_q != ST_IDLE);
	assign cfg_ready   = (state_q == ST_IDLE);
	assign accept      = req_valid && !req_stall;
	assign wr_en       = accept && req_word.kind == KIND_WRITE
	                     && (32'(req_word.entry_index) < 32'(MAX_POINTS));
	assign query_start = accept && req_word.kind == KIND_QUERY;

	assign {rd_pos, rd_val} = rd_entry_s1;
	assign hit     = rd_pos >= q_pos_q;
	assign at_last = chk_idx_s1 == last_idx;

	// last slot in use, count clamped to 1..MAX_POINTS
	always_comb begin
		if (point_count_q == '0) begin
			last_idx = '0;
		end else if (32'(point_count_q) > 32'(MAX_POINTS)) begin
			last_idx = IDX_W'(MAX_POINTS - 1);
		end else begin
			last_idx = IDX_W'(point_count_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			point_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[IDX_W'(req_word.entry_index)] <=
				{req_word.entry_position, req_word.entry_value};
		end
		if (state_q == ST_SEARCH) begin
			rd_entry_s1 <= table_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			addr_q        <= '0;
			chk_v_s1      <= 1'b0;
			chk_idx_s1    <= '0;
			blend_start_q <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			blend_start_q <= 1'b0;
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (query_start) begin
						addr_q   <= '0;
						chk_v_s1 <= 1'b0;
						state_q  <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// read issued at addr_q, checked in the next cycle
					chk_v_s1   <= 1'b1;
					chk_idx_s1 <= addr_q;
					if (addr_q != last_idx) addr_q <= addr_q + 1'b1;
					if (chk_v_s1) begin
						if (hit && chk_idx_s1 == '0) begin
							chk_v_s1 <= 1'b0;
							state_q  <= ST_EMIT;
						end else if (hit) begin
							chk_v_s1      <= 1'b0;
							blend_start_q <= 1'b1;
							state_q       <= ST_BLEND;
						end else if (at_last) begin
							chk_v_s1 <= 1'b0;
							state_q  <= ST_EMIT;
						end
					end
				end
				ST_BLEND: begin
					if (blend_done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= pend_q;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_start) begin
			q_pos_q <= req_word.query_position;
		end
		if (state_q == ST_SEARCH && chk_v_s1) begin
			prev_pos_q <= rd_pos;
			prev_val_q <= rd_val;
			if (hit) begin
				blend_req_q.x1 <= prev_pos_q;
				blend_req_q.y1 <= prev_val_q;
				blend_req_q.x2 <= rd_pos;
				blend_req_q.y2 <= rd_val;
				blend_req_q.q  <= q_pos_q;
				pend_q.result_value <= rd_val;
				pend_q.below_first  <= (chk_idx_s1 == '0);
				pend_q.above_last   <= 1'b0;
				pend_q.segment      <= SEG_W'(chk_idx_s1);
			end else begin
				// clamp-above candidate, replaced if the scan goes on
				pend_q.result_value <= rd_val;
				pend_q.below_first  <= 1'b0;
				pend_q.above_last   <= 1'b1;
				pend_q.segment      <= SEG_W'(chk_idx_s1);
			end
		end
		if (state_q == ST_BLEND && blend_done) begin
			pend_q.result_value <= blend_result;
		end
	end

	plin_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_start_q),
		.req    (blend_req_q),
		.done   (blend_done),
		.result (blend_result)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

`ifndef ASSERT_OFF
	a_chk_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		chk_v_s1 |-> state_q == ST_SEARCH)
		else $error("pending check outside table scan");

	a_chk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chk_v_s1 |-> chk_idx_s1 <= last_idx)
		else $error("table scan passed last slot in use");

	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		blend_done |-> state_q == ST_BLEND)
		else $error("blend done while not waiting for it");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.below_first && rsp_q.above_last))
		else $error("both clamp flags set");
`endif

endmodule
